// ===== design/rsc_pkg.sv =====
// rsc_pkg: shared types and constants for the dkt rotation shape coefficient block
// no dependencies
package rsc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 24;
  localparam int COEF_W         = 32;
  localparam int NUM_EDGES      = 3;

  // edge codes, in emission order
  localparam logic [1:0] EDGE_N12 = 2'd0;
  localparam logic [1:0] EDGE_N02 = 2'd1;
  localparam logic [1:0] EDGE_N01 = 2'd2;

  typedef struct packed {
    logic [1:0]        edge_index;
    logic [COEF_W-1:0] six_dy;
    logic [COEF_W-1:0] dx2_m_2dy2;
    logic [COEF_W-1:0] three_dxdy;
    logic [COEF_W-1:0] six_dx;
    logic [COEF_W-1:0] two_dx2_m_dy2;
    logic              degenerate;
    logic              saturated;
  } rsc_res_t;

endpackage

// ===== design/dkt_rotation_shape_coefficients_core.sv =====
// dkt rotation shape coefficients: three-lane divider pipeline and output merge
// depends on rsc_pkg, rsc_lane, rsc_merge
// the result port sends one edge word a cycle while out_ready is high, three per triangle
// the dividers could take a triangle a cycle; they stall while the merge refuses their output
// reset clears the pipeline valid bits and the merge state; data registers are not reset
module dkt_rotation_shape_coefficients_core
  import rsc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_node0_x,
  input  logic signed [COORD_BITS-1:0] in_node0_y,
  input  logic signed [COORD_BITS-1:0] in_node1_x,
  input  logic signed [COORD_BITS-1:0] in_node1_y,
  input  logic signed [COORD_BITS-1:0] in_node2_x,
  input  logic signed [COORD_BITS-1:0] in_node2_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_edge_index,
  output logic signed [COEF_W-1:0]     out_coef_six_dy,
  output logic signed [COEF_W-1:0]     out_coef_dx2_minus_2dy2,
  output logic signed [COEF_W-1:0]     out_coef_three_dxdy,
  output logic signed [COEF_W-1:0]     out_coef_six_dx,
  output logic signed [COEF_W-1:0]     out_coef_2dx2_minus_dy2,
  output logic                         out_degenerate,
  output logic                         out_saturated,
  output logic                         out_last
);

  // lane depth: difference, product, numerator, FRAC_BITS+4 divider steps, rounding
  localparam int D = FRAC_BITS + 8;

  logic     pv_r [D];
  logic     advance;
  logic     take;
  rsc_res_t lane_res [NUM_EDGES];
  rsc_res_t res;

  // whole pipeline moves together; it holds only when the last stage is full and not taken
  assign advance  = !pv_r[D-1] || take;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D; i++) pv_r[i] <= 1'b0;
    end else if (advance) begin
      pv_r[0] <= in_valid;
      for (int i = 1; i < D; i++) pv_r[i] <= pv_r[i-1];
    end
  end

  // one lane per edge, first node of each edge minus second
  rsc_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .EDGE(EDGE_N12)) u_lane12 (
    .clk (clk), .en (advance),
    .xa (in_node1_x), .ya (in_node1_y), .xb (in_node2_x), .yb (in_node2_y),
    .res_o (lane_res[0])
  );

  rsc_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .EDGE(EDGE_N02)) u_lane02 (
    .clk (clk), .en (advance),
    .xa (in_node0_x), .ya (in_node0_y), .xb (in_node2_x), .yb (in_node2_y),
    .res_o (lane_res[1])
  );

  rsc_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .EDGE(EDGE_N01)) u_lane01 (
    .clk (clk), .en (advance),
    .xa (in_node0_x), .ya (in_node0_y), .xb (in_node1_x), .yb (in_node1_y),
    .res_o (lane_res[2])
  );

  // merge: holds one triangle, loads the next as the last word leaves
  rsc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pv_r[D-1]),
    .take      (take),
    .res_i     (lane_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_o     (res),
    .last      (out_last)
  );

  assign out_edge_index          = res.edge_index;
  assign out_coef_six_dy         = res.six_dy;
  assign out_coef_dx2_minus_2dy2 = res.dx2_m_2dy2;
  assign out_coef_three_dxdy     = res.three_dxdy;
  assign out_coef_six_dx         = res.six_dx;
  assign out_coef_2dx2_minus_dy2 = res.two_dx2_m_dy2;
  assign out_degenerate          = res.degenerate;
  assign out_saturated           = res.saturated;

endmodule

// ===== design/rsc_div.sv =====
// rsc_div: pipelined restoring divider, one quotient bit per stage
// depends on rsc_pkg
module rsc_div
  import rsc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MW        = 2 * COORD_BITS_DEF + 3
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [MW-1:0]        mag_i,
  input  logic [MW-1:0]        den_i,
  input  logic                 neg_i,
  output logic [FRAC_BITS+3:0] q_o,
  output logic                 neg_o
);

  localparam int S  = FRAC_BITS + 4;
  localparam int RW = MW + 1;

  logic [RW-1:0] rem_r [S];
  logic [MW-1:0] den_r [S];
  logic [2:0]    lo_r  [S];
  logic [S-1:0]  q_r   [S];
  logic          neg_r [S];

  for (genvar s = 0; s < S; s++) begin : g_step
    logic [RW-1:0] rem_prev;
    logic [MW-1:0] den_prev;
    logic [2:0]    lo_prev;
    logic [S-1:0]  q_prev;
    logic          neg_prev;
    logic [RW-1:0] trial;
    logic          ge;
    logic [RW-1:0] rem_nxt;

    if (s == 0) begin : g_first
      // mag >> 3 is already below den since the quotient fits S bits
      assign rem_prev = RW'(mag_i >> 3);
      assign den_prev = den_i;
      assign lo_prev  = mag_i[2:0];
      assign q_prev   = '0;
      assign neg_prev = neg_i;
    end else begin : g_rest
      assign rem_prev = rem_r[s-1];
      assign den_prev = den_r[s-1];
      assign lo_prev  = lo_r[s-1];
      assign q_prev   = q_r[s-1];
      assign neg_prev = neg_r[s-1];
    end

    assign trial   = {rem_prev[RW-2:0], lo_prev[2]};
    assign ge      = trial >= {1'b0, den_prev};
    assign rem_nxt = ge ? (trial - {1'b0, den_prev}) : trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        den_r[s] <= den_prev;
        lo_r[s]  <= {lo_prev[1:0], 1'b0};
        q_r[s]   <= {q_prev[S-2:0], ge};
        neg_r[s] <= neg_prev;
      end
    end
  end

  assign q_o   = q_r[S-1];
  assign neg_o = neg_r[S-1];

endmodule

// ===== design/rsc_lane.sv =====
// rsc_lane: one edge - differences, products, numerators, five dividers, rounding
// depends on rsc_pkg and rsc_div
module rsc_lane
  import rsc_pkg::*;
#(
  parameter int         COORD_BITS = COORD_BITS_DEF,
  parameter int         FRAC_BITS  = FRAC_BITS_DEF,
  parameter logic [1:0] EDGE       = EDGE_N12
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] xa,
  input  logic signed [COORD_BITS-1:0] ya,
  input  logic signed [COORD_BITS-1:0] xb,
  input  logic signed [COORD_BITS-1:0] yb,
  output rsc_res_t                     res_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int NW = 2 * COORD_BITS + 4;
  localparam int MW = NW - 1;
  localparam int S  = FRAC_BITS + 4;
  localparam int XW = 40;
  localparam logic [XW-1:0] TOP = XW'(64'h8000_0000);

  logic signed [DW-1:0] dx_r, dy_r, dx2s_r, dy2s_r;
  logic signed [PW-1:0] dx2_r, dy2_r, dxy_r;
  logic [MW-1:0]        mag_r [5];
  logic                 neg_r [5];
  logic [MW-1:0]        l2_r;
  logic                 degen_r;
  logic [S-1:0]         dgn_r;
  rsc_res_t             res_r;

  // stage 1: edge differences
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= DW'(xa) - DW'(xb);
      dy_r <= DW'(ya) - DW'(yb);
    end
  end

  // stage 2: squares and cross product
  always_ff @(posedge clk) begin
    if (en) begin
      dx2_r  <= PW'(dx_r) * PW'(dx_r);
      dy2_r  <= PW'(dy_r) * PW'(dy_r);
      dxy_r  <= PW'(dx_r) * PW'(dy_r);
      dx2s_r <= dx_r;
      dy2s_r <= dy_r;
    end
  end

  // stage 3: numerators as sign and magnitude, squared length
  logic signed [NW-1:0] sdx, sdy, sx2, sy2, sxy, l2w;
  logic signed [NW-1:0] num [5];
  assign sdx = NW'(dx2s_r);
  assign sdy = NW'(dy2s_r);
  assign sx2 = NW'(dx2_r);
  assign sy2 = NW'(dy2_r);
  assign sxy = NW'(dxy_r);
  assign num[0] = (sdy <<< 2) + (sdy <<< 1);
  assign num[1] = sx2 - (sy2 <<< 1);
  assign num[2] = (sxy <<< 1) + sxy;
  assign num[3] = (sdx <<< 2) + (sdx <<< 1);
  assign num[4] = (sx2 <<< 1) - sy2;
  assign l2w    = sx2 + sy2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 5; k++) begin
        neg_r[k] <= num[k][NW-1];
        mag_r[k] <= num[k][NW-1] ? MW'(-num[k]) : MW'(num[k]);
      end
      l2_r    <= MW'(l2w);
      degen_r <= (l2w == '0);
    end
  end

  // divider stages, zero-length flag rides alongside
  logic [S-1:0] q   [5];
  logic         qng [5];
  for (genvar k = 0; k < 5; k++) begin : g_div
    rsc_div #(.FRAC_BITS(FRAC_BITS), .MW(MW)) u_div (
      .clk   (clk),
      .en    (en),
      .mag_i (mag_r[k]),
      .den_i (l2_r),
      .neg_i (neg_r[k]),
      .q_o   (q[k]),
      .neg_o (qng[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) dgn_r <= {dgn_r[S-2:0], degen_r};
  end

  // final stage: round half away from zero, saturate, apply sign
  logic [COEF_W-1:0] val [5];
  logic [4:0]        sat;
  for (genvar k = 0; k < 5; k++) begin : g_fin
    logic [XW-1:0] qt, qr;
    assign qt = XW'(q[k][S-1:1]);
    assign qr = (XW'(q[k]) + XW'(1)) >> 1;
    assign sat[k] = (qt >= TOP) || (!qng[k] && (qr >= TOP));
    always_comb begin
      if (sat[k]) begin
        val[k] = qng[k] ? COEF_W'(TOP) : COEF_W'(TOP - XW'(1));
      end else begin
        val[k] = qng[k] ? COEF_W'(-qr) : COEF_W'(qr);
      end
    end
  end

  logic dg;
  assign dg = dgn_r[S-1];

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.edge_index    <= EDGE;
      res_r.six_dy        <= dg ? '0 : val[0];
      res_r.dx2_m_2dy2    <= dg ? '0 : val[1];
      res_r.three_dxdy    <= dg ? '0 : val[2];
      res_r.six_dx        <= dg ? '0 : val[3];
      res_r.two_dx2_m_dy2 <= dg ? '0 : val[4];
      res_r.degenerate    <= dg;
      res_r.saturated     <= !dg && (|sat);
    end
  end

  assign res_o = res_r;

endmodule

// ===== design/rsc_merge.sv =====
// rsc_merge: takes a triangle's three lane results, sends one word a cycle on out_ready
// depends on rsc_pkg
module rsc_merge
  import rsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     take,
  input  rsc_res_t res_i [NUM_EDGES],
  output logic     out_valid,
  input  logic     out_ready,
  output rsc_res_t res_o,
  output logic     last
);

  rsc_res_t   buf_r [NUM_EDGES];
  logic       busy_r, busy_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign last = (cnt_r == EDGE_N01);
  assign take = in_valid && (!busy_r || (out_ready && last));

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (take) begin
      busy_nxt = 1'b1;
      cnt_nxt  = EDGE_N12;
    end else if (busy_r && out_ready) begin
      if (last) busy_nxt = 1'b0;
      else      cnt_nxt  = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= EDGE_N12;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) buf_r <= res_i;
  end

  assign out_valid = busy_r;
  assign res_o     = buf_r[cnt_r];

endmodule

// ===== design/rsc_checker.sv =====
// rsc_checker: port-level checks on the result channel, bound to the top level
// depends on rsc_pkg
module rsc_checker
  import rsc_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [1:0]               out_edge_index,
  input logic signed [COEF_W-1:0] out_coef_six_dy,
  input logic                     out_degenerate,
  input logic                     out_saturated,
  input logic                     out_last
);

  // a stalled word stays valid and keeps its edge index
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_edge_index))
    else $error("result word changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_edge_index == EDGE_N01)))
    else $error("last flag does not match edge");

  // edges of a triangle leave back to back in order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_edge_index == $past(out_edge_index) + 2'd1))
    else $error("edge sequence broken");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> !out_saturated && (out_coef_six_dy == '0))
    else $error("zero-length edge with non-zero word");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_edge_index != 2'd3))
    else $error("invalid edge code");

endmodule

bind dkt_rotation_shape_coefficients_core rsc_checker u_rsc_checker (.*);
